// ----- hdl/dfmn_pkg.sv -----
// Shared types and constants for the depth frame max-normalize block.
// No dependencies; imported by dfmn_div and depth_frame_max_normalize_8bit_top.
`timescale 1ns / 1ps

package dfmn_pkg;

  localparam int DEF_FRAME_WIDTH  = 640;
  localparam int DEF_FRAME_HEIGHT = 480;
  localparam int DEF_SLOTS        = 3;

  localparam int DEPTH_W = 16;
  localparam int INDEX_W = 19;
  localparam int SLOT_W  = 2;
  localparam int LEVEL_W = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic               go;
    logic               zero;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] maximum;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } div_rsp_t;

endpackage

// ----- hdl/dfmn_div.sv -----
// Iterative scaler: round(depth * 255 / maximum), ties to even, saturated.
// One quotient bit per cycle, then a rounding step. Depends on dfmn_pkg.
`timescale 1ns / 1ps

module dfmn_div import dfmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int NUM_W = DEPTH_W + LEVEL_W;
  localparam int CNT_W = $clog2(LEVEL_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEVEL_W);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEPTH_W-1:0] rem_q;
  logic [LEVEL_W-1:0] low_q;
  logic [LEVEL_W-1:0] quo_q;
  logic [DEPTH_W-1:0] max_q;
  logic               zero_q;
  logic               sat_q;
  logic               done_q;
  logic [LEVEL_W-1:0] level_q;

  logic [NUM_W-1:0]   num;
  logic [DEPTH_W:0]   trial;
  logic [DEPTH_W:0]   diff;
  logic               fits;
  logic [DEPTH_W:0]   twice;
  logic               inc;
  logic [LEVEL_W-1:0] level_d;

  assign num   = {req_i.depth, LEVEL_W'(0)} - NUM_W'(req_i.depth);
  assign trial = {rem_q, low_q[LEVEL_W-1]};
  assign diff  = trial - {1'b0, max_q};
  assign fits  = trial >= {1'b0, max_q};
  assign twice = {rem_q, 1'b0};
  assign inc   = (twice > {1'b0, max_q}) || ((twice == {1'b0, max_q}) && quo_q[0]);

  always_comb begin
    if (zero_q) begin
      level_d = '0;
    end else if (sat_q || (inc && (quo_q == LEVEL_MAX))) begin
      level_d = LEVEL_MAX;
    end else begin
      level_d = quo_q + LEVEL_W'(inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.go) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.go) begin
        rem_q  <= num[NUM_W-1:LEVEL_W];
        low_q  <= num[LEVEL_W-1:0];
        quo_q  <= '0;
        max_q  <= req_i.maximum;
        zero_q <= req_i.zero;
        sat_q  <= num >= {req_i.maximum, LEVEL_W'(0)};
      end
    end else if (cnt_q == LAST_STEP) begin
      level_q <= level_d;
    end else begin
      rem_q <= fits ? diff[DEPTH_W-1:0] : trial[DEPTH_W-1:0];
      low_q <= {low_q[LEVEL_W-2:0], 1'b0};
      quo_q <= {quo_q[LEVEL_W-2:0], fits};
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.level = level_q;

endmodule

// ----- hdl/depth_frame_max_normalize_8bit_top.sv -----
// Top level of the depth frame max-normalize block: frame memory, slot maxima
// and command sequencing. Depends on dfmn_pkg and dfmn_div.
//
//   Channel   Handshake               Payload
//   command   start_i / busy_o        func_i, frame_slot_i, pixel_index_i, depth_i,
//                                     depth_invalid_i, frame_start_i
//   result    done_o (one-cycle)      out_index_o, level_o
//
// A store item does not raise busy_o, so the next item may follow at once. A read item
// keeps busy_o high until after its result strobe, so no new item is taken while it runs;
// the memory read and the bit-serial scaler (8 quotient steps and a rounding step) set this.
// Reset clears the slot maxima and the control state; the frame memory is not cleared.
// The result strobe cannot be held off; done_o is high for exactly one cycle per read.
`timescale 1ns / 1ps

module depth_frame_max_normalize_8bit_top import dfmn_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
  parameter int SLOTS        = DEF_SLOTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               func_i,
  input  logic [SLOT_W-1:0]  frame_slot_i,
  input  logic [INDEX_W-1:0] pixel_index_i,
  input  logic [DEPTH_W-1:0] depth_i,
  input  logic               depth_invalid_i,
  input  logic               frame_start_i,
  output logic               done_o,
  output logic [INDEX_W-1:0] out_index_o,
  output logic [LEVEL_W-1:0] level_o
);

  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ENTRIES      = SLOTS * FRAME_PIXELS;
  localparam int ADDR_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SEL_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_DIV   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [DEPTH_W-1:0] slot_max_q [SLOTS];
  logic [DEPTH_W-1:0] frame_mem_q [ENTRIES];
  logic [DEPTH_W-1:0] rd_data_q;
  logic [DEPTH_W-1:0] max_q;
  logic               ok_q;
  logic [INDEX_W-1:0] index_q;

  logic               accept;
  logic               addr_ok;
  logic [SEL_W-1:0]   sel;
  logic [31:0]        addr_full;
  logic [ADDR_W-1:0]  addr;
  logic [DEPTH_W-1:0] store_val;
  logic [DEPTH_W-1:0] base_max;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign accept    = start_i && !busy_o;
  assign addr_ok   = (32'(frame_slot_i) < 32'(SLOTS)) && (32'(pixel_index_i) < 32'(FRAME_PIXELS));
  assign sel       = frame_slot_i[SEL_W-1:0];
  assign addr_full = 32'(frame_slot_i) * 32'(FRAME_PIXELS) + 32'(pixel_index_i);
  assign addr      = addr_full[ADDR_W-1:0];
  assign store_val = depth_invalid_i ? '0 : depth_i;
  assign base_max  = frame_start_i ? '0 : slot_max_q[sel];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_READ)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        slot_max_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept && (func_i == FUNC_STORE) && addr_ok) begin
        slot_max_q[sel] <= (store_val > base_max) ? store_val : base_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (func_i == FUNC_STORE) begin
        if (addr_ok) begin
          frame_mem_q[addr] <= store_val;
        end
      end else begin
        rd_data_q <= frame_mem_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (func_i == FUNC_READ)) begin
      index_q <= pixel_index_i;
      ok_q    <= addr_ok;
      max_q   <= slot_max_q[sel];
    end
  end

  assign div_req.go      = (state_q == ST_FETCH);
  assign div_req.zero    = !ok_q || (max_q == '0);
  assign div_req.depth   = rd_data_q;
  assign div_req.maximum = max_q;

  dfmn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = div_rsp.done;
  assign out_index_o = index_q;
  assign level_o     = div_rsp.level;

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("Result strobe held for more than one cycle.");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy_o && (state_q == ST_DIV)))
    else $error("Result strobe outside a read.");

  a_store_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FUNC_STORE)) |=> !busy_o)
    else $error("Store item did not complete in one cycle.");

  a_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FUNC_READ)) |=> (busy_o && !done_o))
    else $error("Read item did not hold the block busy.");

endmodule
